@@ rtl/lcdtk_pkg.sv @@
// ============================================================================
// lcdtk_pkg
// Shared types, constants and helpers for the LCD clock timekeeper.
// ============================================================================
package lcdtk_pkg;

    localparam int TICK_W      = 16;
    localparam int SEC_W       = 6;
    localparam int MIN_W       = 6;
    localparam int HOUR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int BCD_W       = 12;
    localparam int STEP_W      = 4;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [TICK_W-1:0] TPS_RESET   = 16'd1000;
    localparam logic [SEC_W-1:0]  SEC_WRAP    = 6'd60;
    localparam logic [MIN_W-1:0]  MIN_WRAP    = 6'd60;

    localparam logic [BYTE_W-1:0] CURSOR_SEC  = 8'h8E;
    localparam logic [BYTE_W-1:0] CURSOR_MIN  = 8'h8B;
    localparam logic [BYTE_W-1:0] CURSOR_HOUR = 8'h89;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;

    // Which fields a new second refreshes.
    typedef enum logic [1:0] {
        KIND_SEC  = 2'd0,
        KIND_MIN  = 2'd1,
        KIND_HOUR = 2'd2
    } t_kind;

    // One queued LCD refresh: kind plus the value of the deepest field.
    typedef struct packed {
        t_kind              kind;
        logic [HOUR_W-1:0]  value;
    } t_burst;

    // Queue read side as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_burst entry;
    } t_fifo_rd;

    // Binary to three BCD digits (double dabble), {hundreds, tens, ones}.
    function automatic logic [BCD_W-1:0] to_bcd(input logic [HOUR_W-1:0] v);
        logic [BCD_W+HOUR_W-1:0] s;
        s = {{BCD_W{1'b0}}, v};
        for (int i = 0; i < HOUR_W; i++) begin
            if (s[HOUR_W+3:HOUR_W] >= 4'd5) begin
                s[HOUR_W+3:HOUR_W] = s[HOUR_W+3:HOUR_W] + 4'd3;
            end
            if (s[HOUR_W+7:HOUR_W+4] >= 4'd5) begin
                s[HOUR_W+7:HOUR_W+4] = s[HOUR_W+7:HOUR_W+4] + 4'd3;
            end
            if (s[HOUR_W+11:HOUR_W+8] >= 4'd5) begin
                s[HOUR_W+11:HOUR_W+8] = s[HOUR_W+11:HOUR_W+8] + 4'd3;
            end
            s = s << 1;
        end
        return s[BCD_W+HOUR_W-1:HOUR_W];
    endfunction

    function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
        return ASCII_ZERO | {4'h0, d};
    endfunction

endpackage

@@ rtl/lcdtk_front.sv @@
// ============================================================================
// lcdtk_front
// Tick prescaler and hh:mm:ss counters; queues one refresh per new second.
// ============================================================================
module lcdtk_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lcdtk_pkg::TICK_W-1:0] i_cfg_wr_data,
    input  logic                        i_accept,
    input  logic                        i_tick,
    output logic                        o_push,
    output lcdtk_pkg::t_burst           o_burst
);

    logic [lcdtk_pkg::TICK_W-1:0] r_tps;
    logic [lcdtk_pkg::TICK_W-1:0] r_tick_count;
    logic [lcdtk_pkg::SEC_W-1:0]  r_sec;
    logic [lcdtk_pkg::MIN_W-1:0]  r_min;
    logic [lcdtk_pkg::HOUR_W-1:0] r_hour;

    logic [lcdtk_pkg::TICK_W-1:0] n_tick_count;
    logic [lcdtk_pkg::SEC_W-1:0]  n_sec;
    logic [lcdtk_pkg::MIN_W-1:0]  n_min;
    logic [lcdtk_pkg::HOUR_W-1:0] n_hour;
    logic                         w_new_sec;
    logic                         w_sec_wrap;
    logic                         w_min_wrap;

    assign n_tick_count = r_tick_count + 1'b1;
    assign n_sec        = r_sec + 1'b1;
    assign n_min        = r_min + 1'b1;
    assign n_hour       = r_hour + 1'b1;
    assign w_new_sec    = i_accept && i_tick && (n_tick_count == r_tps);
    assign w_sec_wrap   = (n_sec >= lcdtk_pkg::SEC_WRAP);
    assign w_min_wrap   = (n_min >= lcdtk_pkg::MIN_WRAP);

    always_comb begin
        o_push = w_new_sec;
        if (!w_sec_wrap) begin
            o_burst.kind  = lcdtk_pkg::KIND_SEC;
            o_burst.value = {2'b00, n_sec};
        end else if (!w_min_wrap) begin
            o_burst.kind  = lcdtk_pkg::KIND_MIN;
            o_burst.value = {2'b00, n_min};
        end else begin
            o_burst.kind  = lcdtk_pkg::KIND_HOUR;
            o_burst.value = n_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= lcdtk_pkg::TPS_RESET;
            r_tick_count <= '0;
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (i_accept && i_tick) begin
                if (w_new_sec) begin
                    r_tick_count <= '0;
                    if (!w_sec_wrap) begin
                        r_sec <= n_sec;
                    end else begin
                        r_sec <= '0;
                        if (!w_min_wrap) begin
                            r_min <= n_min;
                        end else begin
                            r_min  <= '0;
                            r_hour <= n_hour;
                        end
                    end
                end else begin
                    r_tick_count <= n_tick_count;
                end
            end
        end
    end

endmodule

@@ rtl/lcdtk_fifo.sv @@
// ============================================================================
// lcdtk_fifo
// Short queue of pending LCD refreshes between front and back end.
// ============================================================================
module lcdtk_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lcdtk_pkg::t_burst   i_burst,
    input  logic                i_pop,
    output lcdtk_pkg::t_fifo_rd o_rd,
    output logic                o_full
);

    lcdtk_pkg::t_burst                    r_mem [lcdtk_pkg::FIFO_DEPTH];
    logic [lcdtk_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [lcdtk_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [lcdtk_pkg::FIFO_CNT_W-1:0]     r_count;
    logic                                 w_push;
    logic                                 w_pop;

    assign o_full     = (r_count == lcdtk_pkg::FIFO_CNT_W'(lcdtk_pkg::FIFO_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/lcdtk_back.sv @@
// ============================================================================
// lcdtk_back
// Write sequencer: expands one queued refresh into cursor and digit writes.
// ============================================================================
module lcdtk_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcdtk_pkg::t_fifo_rd           i_rd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lcdtk_pkg::BYTE_W-1:0]  o_lcd_byte,
    output logic                          o_to_data_register,
    output logic                          o_last_write
);

    logic                             r_busy;
    lcdtk_pkg::t_kind                 r_kind;
    logic [lcdtk_pkg::BCD_W-1:0]      r_bcd;
    logic [lcdtk_pkg::STEP_W-1:0]     r_step;
    logic                             r_out_valid;
    logic [lcdtk_pkg::BYTE_W-1:0]     r_lcd_byte;
    logic                             r_to_data;
    logic                             r_last;

    logic [3:0]                       w_hun;
    logic [3:0]                       w_ten;
    logic [3:0]                       w_one;
    logic [1:0]                       w_skip;
    logic [lcdtk_pkg::STEP_W-1:0]     w_pos;
    logic [lcdtk_pkg::BYTE_W-1:0]     n_lcd_byte;
    logic                             n_to_data;
    logic                             n_last;
    logic                             w_load;

    assign w_hun  = r_bcd[11:8];
    assign w_ten  = r_bcd[7:4];
    assign w_one  = r_bcd[3:0];
    // hours drop leading zeros: skip the hundreds and maybe the tens
    assign w_skip = (w_hun != 4'd0) ? 2'd0 : ((w_ten != 4'd0) ? 2'd1 : 2'd2);
    assign w_pos  = r_step - 4'd7 + {2'b00, w_skip};

    assign w_load = r_busy && (!r_out_valid || !i_out_stall);
    assign o_pop  = !r_busy && i_rd.valid;

    always_comb begin
        n_lcd_byte = lcdtk_pkg::CURSOR_SEC;
        n_to_data  = 1'b0;
        n_last     = 1'b0;
        unique case (r_kind)
            lcdtk_pkg::KIND_SEC: begin
                case (r_step)
                    4'd0:    begin n_lcd_byte = lcdtk_pkg::CURSOR_SEC; end
                    4'd1:    begin n_lcd_byte = lcdtk_pkg::digit_char(w_ten); n_to_data = 1'b1; end
                    default: begin
                        n_lcd_byte = lcdtk_pkg::digit_char(w_one);
                        n_to_data  = 1'b1;
                        n_last     = 1'b1;
                    end
                endcase
            end
            lcdtk_pkg::KIND_MIN: begin
                case (r_step)
                    4'd0:    begin n_lcd_byte = lcdtk_pkg::CURSOR_SEC; end
                    4'd3:    begin n_lcd_byte = lcdtk_pkg::CURSOR_MIN; end
                    4'd4:    begin n_lcd_byte = lcdtk_pkg::digit_char(w_ten); n_to_data = 1'b1; end
                    4'd5:    begin
                        n_lcd_byte = lcdtk_pkg::digit_char(w_one);
                        n_to_data  = 1'b1;
                        n_last     = 1'b1;
                    end
                    default: begin n_lcd_byte = lcdtk_pkg::ASCII_ZERO; n_to_data = 1'b1; end
                endcase
            end
            default: begin
                case (r_step)
                    4'd0:    begin n_lcd_byte = lcdtk_pkg::CURSOR_SEC; end
                    4'd3:    begin n_lcd_byte = lcdtk_pkg::CURSOR_MIN; end
                    4'd6:    begin n_lcd_byte = lcdtk_pkg::CURSOR_HOUR; end
                    4'd1, 4'd2, 4'd4, 4'd5: begin
                        n_lcd_byte = lcdtk_pkg::ASCII_ZERO;
                        n_to_data  = 1'b1;
                    end
                    default: begin
                        n_to_data = 1'b1;
                        case (w_pos)
                            4'd0:    n_lcd_byte = lcdtk_pkg::digit_char(w_hun);
                            4'd1:    n_lcd_byte = lcdtk_pkg::digit_char(w_ten);
                            default: begin
                                n_lcd_byte = lcdtk_pkg::digit_char(w_one);
                                n_last     = 1'b1;
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_rd.entry.kind;
            r_bcd  <= lcdtk_pkg::to_bcd(i_rd.entry.value);
        end
        if (w_load) begin
            r_lcd_byte <= n_lcd_byte;
            r_to_data  <= n_to_data;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_load) begin
                r_step <= r_step + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_lcd_byte         = r_lcd_byte;
    assign o_to_data_register = r_to_data;
    assign o_last_write       = r_last;

endmodule

@@ rtl/lcd_clock_timekeeper_core.sv @@
// ============================================================================
// lcd_clock_timekeeper_core
// Real-time clock hh:mm:ss driving character-LCD refresh writes.
// ============================================================================
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ---------------------------
//  tick      in         i_in_valid / o_in_stall     i_tick
//  lcd       out        o_out_valid / i_out_stall   o_lcd_byte,
//                                                   o_to_data_register,
//                                                   o_last_write
//  config    in         i_cfg_wr_en                 i_cfg_wr_data
//
//  Ticks are taken every cycle while the refresh queue (2 entries) has room.
//  Each queued refresh is fetched into the sequencer, then gives one LCD
//  write per cycle while the output is not stalled (3, 6 or 8..10 writes)
//  through the output register.
//  Output stalls back up into the queue; only a full queue stalls ticks.
//  Reset (synchronous, active low) zeroes time and the prescaler and loads
//  ticks_per_second = 1000.
// ----------------------------------------------------------------------------
module lcd_clock_timekeeper_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lcdtk_pkg::TICK_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_tick,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lcdtk_pkg::BYTE_W-1:0]  o_lcd_byte,
    output logic                          o_to_data_register,
    output logic                          o_last_write
);

    logic                w_accept;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    lcdtk_pkg::t_burst   w_burst;
    lcdtk_pkg::t_fifo_rd w_rd;

    // Stall whole input while the queue cannot take another refresh.
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    lcdtk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_tick        (i_tick),
        .o_push        (w_push),
        .o_burst       (w_burst)
    );

    lcdtk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_burst (w_burst),
        .i_pop   (w_pop),
        .o_rd    (w_rd),
        .o_full  (w_full)
    );

    lcdtk_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rd               (w_rd),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_lcd_byte         (o_lcd_byte),
        .o_to_data_register (o_to_data_register),
        .o_last_write       (o_last_write)
    );

endmodule

@@ rtl/lcdtk_checker.sv @@
// ============================================================================
// lcdtk_checker
// Port-level checks on the LCD write stream of the timekeeper.
// ============================================================================
module lcdtk_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [lcdtk_pkg::BYTE_W-1:0]  o_lcd_byte,
    input  logic                          o_to_data_register,
    input  logic                          o_last_write
);

    // No write pending coming out of reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Stalled write holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_lcd_byte) && $stable(o_last_write))
        else $error("stalled LCD write changed");

    // Cursor commands go to the instruction register, digits to data.
    a_reg_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_to_data_register == !o_lcd_byte[7]))
        else $error("register select does not match byte kind");

    // Data writes are ASCII digits.
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_to_data_register |->
            (o_lcd_byte[7:4] == 4'h3) && (o_lcd_byte[3:0] <= 4'd9))
        else $error("data write is not a decimal digit");

    // A burst always closes on a digit.
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_write |-> o_to_data_register)
        else $error("burst ends on a cursor command");

endmodule

bind lcd_clock_timekeeper_core lcdtk_checker u_lcdtk_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_lcd_byte         (o_lcd_byte),
    .o_to_data_register (o_to_data_register),
    .o_last_write       (o_last_write)
);

@@ tb/lcd_clock_timekeeper_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcd_clock_timekeeper_checker
// Tracks ticks and period writes, predicts each LCD refresh burst and checks
// every LCD write transaction against the oldest predicted write.
// ============================================================================
module lcd_clock_timekeeper_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lcdtk_pkg::TICK_W-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_tick,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [lcdtk_pkg::BYTE_W-1:0] i_lcd_byte,
    input  logic                         i_to_data_register,
    input  logic                         i_last_write,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);

    typedef struct packed {
        logic [lcdtk_pkg::BYTE_W-1:0] lcd_byte;
        logic                         to_data_register;
        logic                         last_write;
    } t_lcd_write;

    t_lcd_write lcd_writes_due[$];
    t_lcd_write oldest;

    // Predicted clock state and period register.
    logic [lcdtk_pkg::TICK_W-1:0] period;
    logic [lcdtk_pkg::TICK_W-1:0] prescale;
    logic [lcdtk_pkg::SEC_W-1:0]  seconds;
    logic [lcdtk_pkg::MIN_W-1:0]  minutes;
    logic [lcdtk_pkg::HOUR_W-1:0] hours;

    int unsigned failures       = 0;
    int unsigned writes_checked = 0;

    function automatic logic [lcdtk_pkg::BYTE_W-1:0] digit_byte(input int d);
        return lcdtk_pkg::ASCII_ZERO + 8'(d);
    endfunction

    function automatic void queue_write(input logic [lcdtk_pkg::BYTE_W-1:0] b,
                                        input logic is_data);
        t_lcd_write w;
        w.lcd_byte         = b;
        w.to_data_register = is_data;
        w.last_write       = 1'b0;
        lcd_writes_due.push_back(w);
    endfunction

    function automatic void queue_two_digits(input int v);
        queue_write(digit_byte(v / 10), 1'b1);
        queue_write(digit_byte(v % 10), 1'b1);
    endfunction

    // One tick: advance the prescaler; on a new second queue the refresh burst.
    function automatic void count_tick();
        t_lcd_write tail;
        int h;
        prescale = prescale + 1'b1;
        if (prescale != period) begin
            return;
        end
        prescale = '0;
        seconds  = seconds + 1'b1;
        queue_write(lcdtk_pkg::CURSOR_SEC, 1'b0);
        if (seconds >= lcdtk_pkg::SEC_WRAP) begin
            seconds = '0;
            queue_two_digits(0);
            minutes = minutes + 1'b1;
            queue_write(lcdtk_pkg::CURSOR_MIN, 1'b0);
            if (minutes >= lcdtk_pkg::MIN_WRAP) begin
                minutes = '0;
                queue_two_digits(0);
                hours = hours + 1'b1;
                h     = int'(hours);
                queue_write(lcdtk_pkg::CURSOR_HOUR, 1'b0);
                // hours: no leading zeros
                if (h >= 100) begin
                    queue_write(digit_byte(h / 100), 1'b1);
                end
                if (h >= 10) begin
                    queue_write(digit_byte((h / 10) % 10), 1'b1);
                end
                queue_write(digit_byte(h % 10), 1'b1);
            end else begin
                queue_two_digits(int'(minutes));
            end
        end else begin
            queue_two_digits(int'(seconds));
        end
        tail = lcd_writes_due.pop_back();
        tail.last_write = 1'b1;
        lcd_writes_due.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period   = lcdtk_pkg::TPS_RESET;
            prescale = '0;
            seconds  = '0;
            minutes  = '0;
            hours    = '0;
            lcd_writes_due.delete();
        end else begin
            // Check first: a write at this edge can't belong to a tick taken now.
            if (i_out_valid && !i_out_stall) begin
                if (lcd_writes_due.size() == 0) begin
                    if (failures < 10) begin
                        $display("[%0t] LCD write %0d with nothing predicted: %s %h %b %b",
                                 $time, writes_checked, "byte/data/last",
                                 i_lcd_byte, i_to_data_register, i_last_write);
                    end
                    failures++;
                end else begin
                    oldest = lcd_writes_due.pop_front();
                    if (oldest.lcd_byte !== i_lcd_byte ||
                        oldest.to_data_register !== i_to_data_register ||
                        oldest.last_write !== i_last_write) begin
                        if (failures < 10) begin
                            $display("[%0t] LCD write %0d: expected byte %h data %b last %b,",
                                     $time, writes_checked, oldest.lcd_byte,
                                     oldest.to_data_register, oldest.last_write);
                            $display("    got byte %h data %b last %b",
                                     i_lcd_byte, i_to_data_register, i_last_write);
                        end
                        failures++;
                    end
                end
                writes_checked++;
            end
            if (i_cfg_wr_en) begin
                period = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall && i_tick) begin
                count_tick();
            end
        end
        o_pending    <= lcd_writes_due.size();
        o_fail_count <= failures;
    end

endmodule

@@ tb/lcd_clock_timekeeper_core_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcd_clock_timekeeper_core_test
// Drives timer ticks and period writes into the timekeeper under random
// gaps and output stalls; a checker beside the block predicts every LCD write.
// ============================================================================
module lcd_clock_timekeeper_core_test;

    // Watchdog limit, far above what a correct run needs.
    localparam int unsigned CYCLE_LIMIT    = 200_000;
    // Drain time once nothing is predicted: queue fetch plus output register.
    localparam int          SETTLE_CYCLES  = 12;
    localparam int          RANDOM_TICKS   = 120;
    localparam int          SECTION_ITEMS  = 40;
    // Ticks at one tick per second that carry the seconds past 59 twice.
    localparam int          LONG_RUN_TICKS = 110;

    logic                         clk;
    logic                         rst_n            = 1'b0;
    logic                         cfg_wr_en        = 1'b0;
    logic [lcdtk_pkg::TICK_W-1:0] cfg_wr_data      = '0;
    logic                         in_valid         = 1'b0;
    logic                         in_stall;
    logic                         tick             = 1'b0;
    logic                         out_valid;
    logic                         out_stall        = 1'b0;
    logic [lcdtk_pkg::BYTE_W-1:0] lcd_byte;
    logic                         to_data_register;
    logic                         last_write;

    int unsigned fail_count;
    int unsigned pending;

    // Stimulus knobs; the hold flags are shared with the receiver process.
    bit          gaps_on        = 1'b1;
    bit          want_long_hold = 1'b0;
    bit          long_hold_done = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned ticks_taken    = 0;
    int unsigned writes_seen    = 0;
    int unsigned period_writes  = 0;

    lcd_clock_timekeeper_core u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_tick             (tick),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_lcd_byte         (lcd_byte),
        .o_to_data_register (to_data_register),
        .o_last_write       (last_write)
    );

    lcd_clock_timekeeper_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_tick             (tick),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_lcd_byte         (lcd_byte),
        .i_to_data_register (to_data_register),
        .i_last_write       (last_write),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bookkeeping for the summary and the watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                ticks_taken <= ticks_taken + 1;
            end
            if (out_valid && !out_stall) begin
                writes_seen <= writes_seen + 1;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d LCD writes still predicted",
                 cycle_count, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // LCD side: ready runs and stalls of random length. Most stalls are short,
    // some are long; one forced long hold-off lets the refresh queue fill so
    // the tick channel has to stall.
    initial begin
        int  span;
        int  pick;
        logic hold;
        forever begin
            if (want_long_hold && !long_hold_done) begin
                hold           = 1'b1;
                span           = $urandom_range(200, 320);
                long_hold_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    hold = 1'b0;
                    span = $urandom_range(1, 16);
                end else if (pick < 52) begin
                    hold = 1'b0;
                    span = $urandom_range(50, 150);
                end else if (pick < 85) begin
                    hold = 1'b1;
                    span = $urandom_range(1, 3);
                end else if (pick < 97) begin
                    hold = 1'b1;
                    span = $urandom_range(4, 12);
                end else begin
                    hold = 1'b1;
                    span = $urandom_range(20, 60);
                end
            end
            out_stall <= hold;
            repeat (span) @(posedge clk);
        end
    end

    // One tick transaction, optionally after an idle gap. Valid stays high
    // after acceptance so back-to-back transactions follow without a gap.
    task automatic send_tick(input logic value);
        int gap;
        int pick;
        gap = 0;
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 98) begin
                gap = $urandom_range(15, 40);
            end else if (pick >= 90) begin
                gap = $urandom_range(4, 10);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick(1'b1);
    endtask

    // Drop valid, wait until every predicted write has come out, then give
    // the front end time to settle before the period may change.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input logic [lcdtk_pkg::TICK_W-1:0] ticks_per_sec);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= ticks_per_sec;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        period_writes++;
    endtask

    initial begin
        logic [lcdtk_pkg::TICK_W-1:0] period;
        logic                         tick_bit;
        int                           random_ticks;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: period after reset (1000). Idle items interleaved
        // with ten ticks inside the first second produce nothing.
        for (int k = 0; k < 20; k++) begin
            send_tick(k[0]);
        end
        wait_for_idle();

        // --- directed: period lowered to 16 with the count at 10; the sixth
        // tick after that ends the first second.
        write_period(16'd16);
        send_ticks(6);
        wait_for_idle();

        // --- directed: one tick per second; seconds 2..12 cross the point
        // where the tens digit turns nonzero. Idle items mixed in.
        write_period(16'd1);
        for (int k = 0; k < 14; k++) begin
            send_tick(k % 4 != 3);
        end

        // --- one tick per second, no sender gaps: two minute rollovers. The
        // long LCD hold-off lands here while ticks keep coming, so the queue
        // fills and the tick channel stalls.
        gaps_on        = 1'b0;
        want_long_hold = 1'b1;
        send_ticks(LONG_RUN_TICKS);
        wait_for_idle();

        // --- random sections. The prescaler is zero here; the period only
        // grows from section to section, so it never lands below the count
        // and no section turns into a 65536-tick wait.
        gaps_on      = 1'b1;
        period       = 16'd1;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            write_period(period);
            repeat (SECTION_ITEMS) begin
                tick_bit = ($urandom_range(0, 9) < 8);
                send_tick(tick_bit);
                if (tick_bit) begin
                    random_ticks++;
                end
            end
            wait_for_idle();
            if (period < 16'd52) begin
                period = period + 16'($urandom_range(1, 12));
            end
        end

        $display("Run: %0d tick transactions, %0d LCD writes, %0d period writes",
                 ticks_taken, writes_seen, period_writes);
        $display("Periods of 1000, 16, 1 and a rising random set; seconds and minute %s",
                 "rollovers, with the tick channel held off by a full queue");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lcdtk_pkg.sv
rtl/lcdtk_front.sv
rtl/lcdtk_fifo.sv
rtl/lcdtk_back.sv
rtl/lcd_clock_timekeeper_core.sv
rtl/lcdtk_checker.sv
tb/lcd_clock_timekeeper_checker.sv
tb/lcd_clock_timekeeper_core_test.sv
